// File: hdl/wpi_pkg.sv
`default_nettype none
package wpi_pkg;

  localparam int MaxPoints = 64;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = IdxW + 1;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_SHORT = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] t;
  } point_t;

  typedef struct packed {
    logic start;
    logic sqrt;
  } unit_op_t;

endpackage
`default_nettype wire

// File: hdl/wpi_mem.sv
`default_nettype none
module wpi_mem (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [wpi_pkg::IdxW-1:0] waddr_i,
  input  wire wpi_pkg::point_t          wdata_i,
  input  wire logic [wpi_pkg::IdxW-1:0] raddr_i,
  output wpi_pkg::point_t               rdata_o
);
  import wpi_pkg::*;

  point_t mem_q [MaxPoints];
  point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// File: hdl/wpi_unit.sv
`default_nettype none
// shared restoring step: 64-step divide or 33-step square root
module wpi_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire wpi_pkg::unit_op_t op_i,
  input  wire logic [65:0]       op_a_i,
  input  wire logic [31:0]       op_b_i,
  output logic                   done_o,
  output logic [63:0]            res_o
);
  import wpi_pkg::*;

  logic [65:0] acc_q, acc_d;
  logic [35:0] rem_q, rem_d;
  logic [63:0] res_q, res_d;
  logic [31:0] div_q;
  logic        sqrt_q;
  logic [6:0]  cnt_q, cnt_d;
  logic        run_q, run_d, done_q, done_d;
  logic [32:0] div_rs;
  logic [35:0] sq_rs, cmp_a, cmp_b;
  logic [36:0] diff;
  logic        ge;

  always_comb begin
    div_rs = {rem_q[31:0], acc_q[65]};
    sq_rs  = {rem_q[33:0], acc_q[65:64]};
    cmp_a  = sqrt_q ? sq_rs : {3'b0, div_rs};
    cmp_b  = sqrt_q ? {res_q[33:0], 2'b01} : {4'b0, div_q};
    diff   = {1'b0, cmp_a} - {1'b0, cmp_b};
    ge     = ~diff[36];
    acc_d  = acc_q;
    rem_d  = rem_q;
    res_d  = res_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (op_i.start) begin
      acc_d = op_a_i;
      rem_d = '0;
      res_d = '0;
      cnt_d = op_i.sqrt ? 7'd33 : 7'd64;
      run_d = 1'b1;
    end else if (run_q) begin
      acc_d = sqrt_q ? {acc_q[63:0], 2'b00} : {acc_q[64:0], 1'b0};
      rem_d = ge ? diff[35:0] : cmp_a;
      res_d = {res_q[62:0], ge};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    res_q <= res_d;
    if (op_i.start) begin
      div_q  <= op_b_i;
      sqrt_q <= op_i.sqrt;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;
endmodule
`default_nettype wire

// File: hdl/waypoint_path_interpolator_top.sv
`default_nettype none
// Append (after the first point) runs a 33-step root and, unless speed is zero, a
// 64-step divide; a query scans the table and may run two 64-step divides.
// Throughput: one transaction at a time; input stalls until the result is staged.
// Reset: point count and path length clear, speed returns to 1.0; stored points
// are undefined until written.
module waypoint_path_interpolator_top (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [31:0]              cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [1:0]               kind_i,
  input  wire logic signed [31:0]       way_x_i,
  input  wire logic signed [31:0]       way_y_i,
  input  wire logic [31:0]              query_time_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [31:0]            pos_x_o,
  output logic signed [31:0]            pos_y_o,
  output logic                          goal_reached_o,
  output logic [wpi_pkg::IdxW-1:0]      from_index_o,
  output logic [wpi_pkg::IdxW-1:0]      to_index_o,
  output logic [1:0]                    status_o
);
  import wpi_pkg::*;

  typedef enum logic [23:0] {
    S_IDLE = 24'h000001, S_ARD  = 24'h000002, S_AABS = 24'h000004,
    S_AMX  = 24'h000008, S_AMY  = 24'h000010, S_ASQ  = 24'h000020,
    S_ASQW = 24'h000040, S_ADV  = 24'h000080, S_ADVW = 24'h000100,
    S_AWR  = 24'h000200, S_QLR  = 24'h000400, S_QLC  = 24'h000800,
    S_QSR  = 24'h001000, S_QSC  = 24'h002000, S_QRA  = 24'h004000,
    S_QRB  = 24'h008000, S_QSET = 24'h010000, S_QMX  = 24'h020000,
    S_QDX  = 24'h040000, S_QDXW = 24'h080000, S_QMY  = 24'h100000,
    S_QDY  = 24'h200000, S_QDYW = 24'h400000, S_FIN  = 24'h800000
  } state_e;

  state_e state_q;

  logic [31:0]     speed_q, path_len_q, arr_q;
  logic [CntW-1:0] count_q, cnt_m1, cnt_m2;
  logic [31:0]     wx_q, wy_q, t_q;
  logic [IdxW-1:0] idx_q, seg_q;
  logic [31:0]     dmx_q, dmy_q, num_q, den_q, xa_q, ya_q, t0_q;
  logic            negx_q, negy_q;
  logic [63:0]     prod_q;
  // square of x magnitude, held across the y multiply
  logic [63:0]     sqx_q;
  logic [31:0]     mul_a, mul_b;
  logic [31:0]     rx_q, ry_q;
  logic            goal_q;
  logic [IdxW-1:0] from_q, to_q;
  logic [1:0]      st_q;
  logic            ov_q;
  logic [31:0]     ox_q, oy_q;
  logic            og_q;
  logic [IdxW-1:0] of_q, ot_q;
  logic [1:0]      os_q;

  point_t          rd, wdata;
  logic [IdxW-1:0] raddr;
  unit_op_t        uop;
  logic [65:0]     u_a;
  logic [31:0]     u_b;
  logic            u_done;
  logic [63:0]     u_res;

  logic [32:0] ddx, ddy;
  logic [33:0] len;
  logic        accept;

  assign cnt_m1 = count_q - CntW'(1);
  assign cnt_m2 = count_q - CntW'(2);
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    case (state_q)
      S_ARD, S_QLR: raddr = cnt_m1[IdxW-1:0];
      S_QSR:        raddr = idx_q;
      S_QRA:        raddr = seg_q;
      S_QRB:        raddr = seg_q + IdxW'(1);
      default:      raddr = '0;
    endcase
  end

  assign wdata = '{x: wx_q, y: wy_q, t: arr_q};

  wpi_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (state_q == S_AWR),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  always_comb begin
    uop.start = (state_q == S_ASQ) || (state_q == S_ADV) ||
                (state_q == S_QDX) || (state_q == S_QDY);
    uop.sqrt  = (state_q == S_ASQ);
    case (state_q)
      S_ASQ:   u_a = {1'b0, 65'(sqx_q) + 65'(prod_q)};
      S_ADV:   u_a = {16'b0, path_len_q, 16'b0, 2'b00};
      default: u_a = {prod_q, 2'b00};
    endcase
    u_b = (state_q == S_ADV) ? speed_q : den_q;
  end

  wpi_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (uop),
    .op_a_i (u_a),
    .op_b_i (u_b),
    .done_o (u_done),
    .res_o  (u_res)
  );

  assign mul_a = (state_q == S_AMY || state_q == S_QMY) ? dmy_q : dmx_q;
  assign mul_b = (state_q == S_QMX || state_q == S_QMY) ? num_q : mul_a;

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a) * 64'(mul_b);
  end

  always_comb begin
    ddx = {rd.x[31], rd.x} - {wx_q[31], wx_q};
    ddy = {rd.y[31], rd.y} - {wy_q[31], wy_q};
    if (state_q == S_QSET) begin
      ddx = {rd.x[31], rd.x} - {xa_q[31], xa_q};
      ddy = {rd.y[31], rd.y} - {ya_q[31], ya_q};
    end
    len = {2'b0, path_len_q} + u_res[33:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      speed_q    <= 32'h0001_0000;
      count_q    <= '0;
      path_len_q <= '0;
      ov_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        speed_q <= cfg_wdata_i;
      end
      if (state_q == S_FIN && (!ov_q || !out_stall_i)) begin
        ov_q <= 1'b1;
      end else if (ov_q && !out_stall_i) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_FIN;
            if (kind_i == KIND_CLEAR) begin
              count_q    <= '0;
              path_len_q <= '0;
            end else if (kind_i == KIND_APPEND) begin
              if (count_q == CntW'(MaxPoints)) begin
                state_q <= S_FIN;
              end else if (count_q == '0) begin
                path_len_q <= '0;
                state_q    <= S_AWR;
              end else begin
                state_q <= S_ARD;
              end
            end else if (kind_i == KIND_QUERY) begin
              if (count_q >= CntW'(2)) begin
                state_q <= S_QLR;
              end
            end
          end
        end
        S_ARD:  state_q <= S_AABS;
        S_AABS: state_q <= S_AMX;
        S_AMX:  state_q <= S_AMY;
        S_AMY:  state_q <= S_ASQ;
        S_ASQ:  state_q <= S_ASQW;
        S_ASQW: begin
          if (u_done) begin
            path_len_q <= (len[33:32] != 2'b0) ? 32'hFFFF_FFFF : len[31:0];
            state_q    <= (speed_q == '0) ? S_AWR : S_ADV;
          end
        end
        S_ADV:  state_q <= S_ADVW;
        S_ADVW: if (u_done) state_q <= S_AWR;
        S_AWR: begin
          count_q <= count_q + CntW'(1);
          state_q <= S_FIN;
        end
        S_QLR:  state_q <= S_QLC;
        S_QLC:  state_q <= (t_q > rd.t) ? S_FIN : S_QSR;
        S_QSR:  state_q <= S_QSC;
        S_QSC:  state_q <= (idx_q == cnt_m2[IdxW-1:0]) ? S_QRA : S_QSR;
        S_QRA:  state_q <= S_QRB;
        S_QRB:  state_q <= S_QSET;
        S_QSET: state_q <= (rd.t > t0_q) ? S_QMX : S_FIN;
        S_QMX:  state_q <= S_QDX;
        S_QDX:  state_q <= S_QDXW;
        S_QDXW: if (u_done) state_q <= S_QMY;
        S_QMY:  state_q <= S_QDY;
        S_QDY:  state_q <= S_QDYW;
        S_QDYW: if (u_done) state_q <= S_FIN;
        S_FIN: begin
          if (!ov_q || !out_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        wx_q   <= way_x_i;
        wy_q   <= way_y_i;
        t_q    <= query_time_i;
        arr_q  <= '0;
        rx_q   <= '0;
        ry_q   <= '0;
        goal_q <= 1'b0;
        from_q <= '0;
        to_q   <= '0;
        st_q   <= STAT_OK;
        idx_q  <= '0;
        seg_q  <= '0;
        if (kind_i == KIND_APPEND && count_q == CntW'(MaxPoints)) begin
          st_q <= STAT_FULL;
        end
        if (kind_i == KIND_QUERY && count_q < CntW'(2)) begin
          st_q <= STAT_SHORT;
        end
      end
      S_AABS: begin
        dmx_q <= ddx[32] ? 32'(-ddx) : ddx[31:0];
        dmy_q <= ddy[32] ? 32'(-ddy) : ddy[31:0];
      end
      S_AMY: sqx_q <= prod_q;
      S_ASQW: if (u_done && speed_q == '0) arr_q <= 32'hFFFF_FFFF;
      S_ADVW: begin
        if (u_done) begin
          arr_q <= (u_res[63:32] != '0) ? 32'hFFFF_FFFF : u_res[31:0];
        end
      end
      S_QLC: begin
        if (t_q > rd.t) begin
          rx_q   <= rd.x;
          ry_q   <= rd.y;
          goal_q <= 1'b1;
          from_q <= cnt_m2[IdxW-1:0];
          to_q   <= cnt_m1[IdxW-1:0];
        end
      end
      S_QSC: begin
        if (t_q > rd.t) seg_q <= idx_q;
        idx_q <= idx_q + IdxW'(1);
      end
      S_QRB: begin
        xa_q <= rd.x;
        ya_q <= rd.y;
        t0_q <= rd.t;
      end
      S_QSET: begin
        num_q  <= (t_q > t0_q) ? t_q - t0_q : '0;
        den_q  <= rd.t - t0_q;
        negx_q <= ddx[32];
        negy_q <= ddy[32];
        dmx_q  <= ddx[32] ? 32'(-ddx) : ddx[31:0];
        dmy_q  <= ddy[32] ? 32'(-ddy) : ddy[31:0];
        rx_q   <= xa_q;
        ry_q   <= ya_q;
        from_q <= seg_q;
        to_q   <= seg_q + IdxW'(1);
      end
      S_QDXW: if (u_done) rx_q <= negx_q ? xa_q - u_res[31:0] : xa_q + u_res[31:0];
      S_QDYW: if (u_done) ry_q <= negy_q ? ya_q - u_res[31:0] : ya_q + u_res[31:0];
      S_FIN: begin
        if (!ov_q || !out_stall_i) begin
          ox_q <= rx_q;
          oy_q <= ry_q;
          og_q <= goal_q;
          of_q <= from_q;
          ot_q <= to_q;
          os_q <= st_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = ov_q;
  assign pos_x_o        = ox_q;
  assign pos_y_o        = oy_q;
  assign goal_reached_o = og_q;
  assign from_index_o   = of_q;
  assign to_index_o     = ot_q;
  assign status_o       = os_q;
endmodule
`default_nettype wire

// File: tb/testbench.sv
module testbench;
  import wpi_pkg::*;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               goal;
    logic [IdxW-1:0]    from_idx;
    logic [IdxW-1:0]    to_idx;
    logic [1:0]         status;
  } position_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] kind_i = KIND_CLEAR;
  logic signed [31:0] way_x_i = '0;
  logic signed [31:0] way_y_i = '0;
  logic [31:0] query_time_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic signed [31:0] pos_x_o, pos_y_o;
  logic goal_reached_o;
  logic [IdxW-1:0] from_index_o, to_index_o;
  logic [1:0] status_o;

  waypoint_path_interpolator_top i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .kind_i, .way_x_i, .way_y_i, .query_time_i,
    .out_valid_o, .out_stall_i, .pos_x_o, .pos_y_o, .goal_reached_o,
    .from_index_o, .to_index_o, .status_o
  );

  localparam int WatchdogLimit = 20000;

  // path model
  logic [31:0] wp_x [MaxPoints];
  logic [31:0] wp_y [MaxPoints];
  logic [31:0] wp_arrival [MaxPoints];
  int unsigned wp_count = 0;
  logic [31:0] route_length = '0;
  logic [31:0] speed_reg = 32'd65536;

  position_t expected_positions[$];
  int mismatches = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  bit no_idle = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [63:0] floor_sqrt(logic [64:0] v);
    logic [66:0] rem;
    logic [66:0] root;
    logic [66:0] trial;
    rem = '0;
    root = '0;
    for (int k = 32; k >= 0; k--) begin
      rem = (rem << 2) | ((v >> (2 * k)) & 65'd3);
      trial = (root << 2) | 67'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 67'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[63:0];
  endfunction

  function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b,
                                        longint unsigned num, longint unsigned den);
    longint sa;
    longint d;
    longint unsigned md;
    longint unsigned q;
    longint r;
    sa = longint'(signed'(a));
    d = longint'(signed'(b)) - sa;
    if (den == 0) return a;
    md = (d < 0) ? longint'(-d) : d;
    q = (md * num) / den;
    r = (d < 0) ? sa - longint'(q) : sa + longint'(q);
    return r[31:0];
  endfunction

  task automatic predict_position(input logic [1:0] kind, input logic [31:0] wx,
                                  input logic [31:0] wy, input logic [31:0] t,
                                  output position_t res);
    longint unsigned ax, ay, px, py, lo, len, q;
    logic [64:0] sq;
    logic [31:0] arr;
    int unsigned seg;
    longint unsigned t0, t1, num, den;
    res = '{default: '0};
    case (kind)
      KIND_CLEAR: begin
        wp_count = 0;
        route_length = '0;
      end
      KIND_APPEND: begin
        if (wp_count >= MaxPoints) begin
          res.status = STAT_FULL;
        end else begin
          if (wp_count == 0) begin
            route_length = '0;
            arr = '0;
          end else begin
            ax = longint'(signed'(wx)) - longint'(signed'(wp_x[wp_count-1]));
            ay = longint'(signed'(wy)) - longint'(signed'(wp_y[wp_count-1]));
            if (longint'(ax) < 0) ax = -longint'(ax);
            if (longint'(ay) < 0) ay = -longint'(ay);
            px = ax * ax;
            py = ay * ay;
            lo = px + py;
            sq = {(lo < px) ? 1'b1 : 1'b0, lo};
            len = longint'(route_length) + floor_sqrt(sq);
            if (len > 64'hFFFF_FFFF) len = 64'hFFFF_FFFF;
            route_length = len[31:0];
            if (speed_reg == 0) begin
              arr = '1;
            end else begin
              q = ({32'd0, route_length} << 16) / {32'd0, speed_reg};
              arr = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
            end
          end
          wp_x[wp_count] = wx;
          wp_y[wp_count] = wy;
          wp_arrival[wp_count] = arr;
          wp_count++;
        end
      end
      KIND_QUERY: begin
        if (wp_count < 2) begin
          res.status = STAT_SHORT;
        end else if (t > wp_arrival[wp_count-1]) begin
          res.pos_x = wp_x[wp_count-1];
          res.pos_y = wp_y[wp_count-1];
          res.goal = 1'b1;
          res.from_idx = IdxW'(wp_count - 2);
          res.to_idx = IdxW'(wp_count - 1);
        end else begin
          seg = 0;
          for (int unsigned i = 0; i + 1 < wp_count; i++)
            if (t > wp_arrival[i]) seg = i;
          t0 = wp_arrival[seg];
          t1 = wp_arrival[seg+1];
          num = (t > t0) ? t - t0 : 0;
          den = (t1 > t0) ? t1 - t0 : 0;
          res.pos_x = blend(wp_x[seg], wp_x[seg+1], num, den);
          res.pos_y = blend(wp_y[seg], wp_y[seg+1], num, den);
          res.from_idx = IdxW'(seg);
          res.to_idx = IdxW'(seg + 1);
        end
      end
      default: ;
    endcase
  endtask

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic send_item(input logic [1:0] kind, input logic [31:0] wx,
                           input logic [31:0] wy, input logic [31:0] t);
    int gap;
    position_t res;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    kind_i = kind;
    way_x_i = wx;
    way_y_i = wy;
    query_time_i = t;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    predict_position(kind, wx, wy, t, res);
    expected_positions.push_back(res);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_positions.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_speed(input logic [31:0] value);
    drain();
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    speed_reg = value;
  endtask

  // result side
  initial begin
    int gap;
    position_t exp_r;
    forever begin
      gap = draw_gap();
      repeat (gap) begin
        @(negedge clk_i);
        out_stall_i = 1'b1;
      end
      @(negedge clk_i);
      out_stall_i = 1'b0;
      forever begin
        @(posedge clk_i);
        if (out_valid_o) break;
      end
      if (expected_positions.size() == 0) begin
        if (mismatches < 10) $display("unexpected transaction at output");
        mismatches++;
      end else begin
        exp_r = expected_positions.pop_front();
        if (pos_x_o !== exp_r.pos_x || pos_y_o !== exp_r.pos_y ||
            goal_reached_o !== exp_r.goal || from_index_o !== exp_r.from_idx ||
            to_index_o !== exp_r.to_idx || status_o !== exp_r.status) begin
          if (mismatches < 10)
            $display({"mismatch: exp x=%h y=%h g=%b f=%0d t=%0d s=%0d",
                      " / got x=%h y=%h g=%b f=%0d t=%0d s=%0d"},
                     exp_r.pos_x, exp_r.pos_y, exp_r.goal, exp_r.from_idx, exp_r.to_idx,
                     exp_r.status, pos_x_o, pos_y_o, goal_reached_o, from_index_o,
                     to_index_o, status_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_short_path();
    send_item(KIND_QUERY, '0, '0, 32'h0001_0000);
    send_item(KIND_APPEND, 32'h0001_0000, 32'h0002_0000, '0);
    send_item(KIND_QUERY, '0, '0, '0);
    send_item(KIND_CLEAR, '0, '0, '0);
  endtask

  task automatic test_square_path();
    send_item(KIND_APPEND, '0, '0, '0);
    send_item(KIND_APPEND, 32'h0003_0000, 32'h0004_0000, '0);
    send_item(KIND_APPEND, 32'h0003_0000, 32'h0004_0000, '0);
    send_item(KIND_APPEND, 32'hFFFF_0000, 32'h0001_8000, '0);
    send_item(KIND_QUERY, '0, '0, '0);
    send_item(KIND_QUERY, '0, '0, 32'h0002_8000);
    send_item(KIND_QUERY, '0, '0, 32'h0005_0000);
    send_item(KIND_QUERY, '0, '0, 32'h0006_0000);
    send_item(KIND_QUERY, '0, '0, 32'hFFFF_FFFF);
  endtask

  task automatic test_extreme_points();
    send_item(KIND_CLEAR, '0, '0, '0);
    send_item(KIND_APPEND, 32'h8000_0000, 32'h8000_0000, '0);
    send_item(KIND_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
    send_item(KIND_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, '0);
    send_item(KIND_QUERY, '0, '0, 32'h8000_0000);
    send_item(KIND_QUERY, '0, '0, 32'hFFFF_FFFF);
  endtask

  task automatic test_speed_extremes();
    write_speed(32'd1);
    send_item(KIND_CLEAR, '0, '0, '0);
    send_item(KIND_APPEND, 32'h0000_0001, '0, '0);
    send_item(KIND_APPEND, 32'h0100_0000, 32'h0100_0000, '0);
    send_item(KIND_QUERY, '0, '0, 32'h7FFF_0000);
    write_speed(32'hFFFF_FFFF);
    send_item(KIND_APPEND, 32'hFF00_0000, 32'h0100_0000, '0);
    send_item(KIND_QUERY, '0, '0, 32'hFFFF_FFFE);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h0000_FFFF)) - 32'sh8000);
      default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_speed();
    case ($urandom_range(0, 4))
      0: return 32'd65536;
      1: return $urandom_range(1, 1024);
      2: return $urandom_range(1, 32'h00FF_FFFF);
      3: return 32'hFFFF_FFFF;
      default: return ($urandom() | 32'd1);
    endcase
  endfunction

  function automatic logic [31:0] rand_time();
    int unsigned k;
    logic [31:0] base;
    if (wp_count == 0 || $urandom_range(0, 4) == 0) return $urandom();
    k = $urandom_range(0, wp_count - 1);
    base = wp_arrival[k];
    case ($urandom_range(0, 3))
      0: return base;
      1: return base + 32'd1;
      2: return base - 32'd1;
      default: return base + $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  task automatic test_random_paths();
    int npts;
    int nq;
    while (items_sent < 580) begin
      no_idle = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 2) == 0) write_speed(rand_speed());
      send_item(KIND_CLEAR, rand_coord(), rand_coord(), $urandom());
      npts = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 67) : $urandom_range(1, 10);
      for (int i = 0; i < npts; i++) begin
        send_item(KIND_APPEND, rand_coord(), rand_coord(), $urandom());
        if ($urandom_range(0, 3) == 0)
          send_item(KIND_QUERY, rand_coord(), rand_coord(), rand_time());
      end
      nq = $urandom_range(2, 8);
      for (int i = 0; i < nq; i++)
        send_item(KIND_QUERY, rand_coord(), rand_coord(), rand_time());
    end
    no_idle = 0;
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    test_short_path();
    test_square_path();
    test_extreme_points();
    test_speed_extremes();
    write_speed(32'd65536);
    test_random_paths();
    drain();
    repeat (200) @(negedge clk_i);
    if (mismatches == 0 && expected_positions.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
